/* rtl/core/strf_pkg.sv */
package strf_pkg;

    localparam int CFG_DATA_W = 4;
    localparam int MODE_W     = 2;
    localparam int PIXEL_W    = 32;

    // register indexes on the configuration port
    localparam logic REG_TILE_SIDE      = 1'b0;
    localparam logic REG_TRANSFORM_MODE = 1'b1;

    // transform codes
    localparam logic [MODE_W-1:0] MODE_ROT_CCW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_CW     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIRROR_ROW = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MIRROR_COL = 2'd3;

    localparam logic [CFG_DATA_W-1:0] TILE_SIDE_RESET = 4'd8;

    typedef struct packed {
        logic load_px;   // write input pixel into the store
        logic rd;        // read store entry for current output position
        logic emit;      // move read data into output register, advance position
    } strf_cmd_t;

    typedef struct packed {
        logic tile_done; // this input pixel completes the tile
        logic last_pos;  // output position is the final one of the tile
        logic out_free;  // output register empty or being drained
    } strf_stat_t;

endpackage

/* rtl/core/strf_ctrl.sv */
module strf_ctrl
    import strf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  strf_stat_t stat,
    output strf_cmd_t  cmd
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready    = (state_reg == ST_LOAD);
    assign cmd.load_px = s_tvalid && (state_reg == ST_LOAD);
    assign cmd.rd      = (state_reg == ST_RD);
    assign cmd.emit    = (state_reg == ST_WR) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cmd.load_px && stat.tile_done)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_pos ? ST_LOAD : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/strf_dp.sv */
module strf_dp
    import strf_pkg::*;
#(
    parameter int MAX_SIDE = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [PIXEL_W-1:0]    s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,
    output logic                  m_tlast,
    input  strf_cmd_t             cmd,
    output strf_stat_t            stat
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RAWW  = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] side_cfg_reg;
    logic [MODE_W-1:0]     mode_reg;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_inc;
    logic [SW-1:0]         y_reg;
    logic [SW-1:0]         x_reg;

    logic [PIXEL_W-1:0]    store [DEPTH];
    logic [PIXEL_W-1:0]    rd_data_reg;

    logic                  out_valid_reg;
    logic [PIXEL_W-1:0]    out_data_reg;
    logic                  out_last_reg;

    logic [RAWW-1:0]       side_raw;
    logic [SW-1:0]         side;
    logic [SW-1:0]         side_m1;
    logic [2*SW-1:0]       side_sq;
    logic [CW-1:0]         total;
    logic [SW-1:0]         src_r;
    logic [SW-1:0]         src_c;
    logic [2*SW-1:0]       src_full;
    logic [AW-1:0]         src_addr;

    // zero acts as one, anything above the maximum saturates
    always_comb
    begin
        side_raw = RAWW'(side_cfg_reg);
        if (side_raw == '0)
        begin
            side = SW'(1);
        end
        else if (side_raw > RAWW'(MAX_SIDE))
        begin
            side = SW'(MAX_SIDE);
        end
        else
        begin
            side = SW'(side_raw);
        end
    end

    assign side_m1   = side - SW'(1);
    assign side_sq   = (2*SW)'(side) * (2*SW)'(side);
    assign total     = CW'(side_sq);
    assign count_inc = count_reg + CW'(1);

    always_comb
    begin
        unique case (mode_reg)
            MODE_ROT_CCW:
            begin
                src_r = x_reg;
                src_c = side_m1 - y_reg;
            end
            MODE_ROT_CW:
            begin
                src_r = side_m1 - x_reg;
                src_c = y_reg;
            end
            MODE_MIRROR_ROW:
            begin
                src_r = side_m1 - y_reg;
                src_c = x_reg;
            end
            default:
            begin
                src_r = y_reg;
                src_c = side_m1 - x_reg;
            end
        endcase
    end

    assign src_full = (2*SW)'(src_r) * (2*SW)'(side) + (2*SW)'(src_c);
    assign src_addr = src_full[AW-1:0];

    assign stat.tile_done = (count_inc >= total);
    assign stat.last_pos  = (y_reg == side_m1) && (x_reg == side_m1);
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_px)
        begin
            store[count_reg[AW-1:0]] <= s_tdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store[src_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= stat.last_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg  <= TILE_SIDE_RESET;
            mode_reg      <= MODE_ROT_CCW;
            count_reg     <= '0;
            y_reg         <= '0;
            x_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_TILE_SIDE:      side_cfg_reg <= cfg_wdata;
                    REG_TRANSFORM_MODE: mode_reg     <= cfg_wdata[MODE_W-1:0];
                    default:            ;
                endcase
            end

            if (cmd.load_px)
            begin
                if (stat.tile_done)
                begin
                    count_reg <= '0;
                    y_reg     <= '0;
                    x_reg     <= '0;
                end
                else
                begin
                    count_reg <= count_inc;
                end
            end
            else if (cmd.emit)
            begin
                if (x_reg == side_m1)
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + SW'(1);
                end
                else
                begin
                    x_reg <= x_reg + SW'(1);
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/square_tile_rotate_flip.sv */
// Channel   Dir  Payload
// s_*       in   tdata[31:0] = pixel_in
// m_*       out  tdata[31:0] = pixel_out, tlast = last_pixel
// cfg_*     in   addr 0 = tile_side[3:0], addr 1 = transform_mode[1:0]
//
// Load: one pixel per cycle into the tile store; s_tready is low while a tile is emitted.
// Emit: each output pixel goes through the store read port, then the output register;
// a tile's emission takes longer if m_tready stalls.
// The last output pixel may wait in the output register while the next tile loads.
// Reset (rst_n, async low): tile_side 8, transform_mode 0, load count 0.
module square_tile_rotate_flip
    import strf_pkg::*;
#(
    parameter int MAX_SIDE = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // [31:0] pixel_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,   // [31:0] pixel_out
    output logic                  m_tlast
);

    strf_cmd_t  cmd;
    strf_stat_t stat;

    strf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    strf_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_px && (cmd.rd || cmd.emit)))
        else $error("store write during emission");

    // a read is always followed by the output stage, never by loading
    a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> !s_tready)
        else $error("input accepted right after store read");

    // after the final pixel of a tile goes out, loading resumes
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.last_pos |=> s_tready && m_tvalid && m_tlast)
        else $error("no return to load after last pixel");

endmodule

/* test/tb_square_tile_rotate_flip.sv */
module tb_square_tile_rotate_flip
    import strf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIDE      = 8;
    localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } out_pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata;   // [31:0] pixel_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIXEL_W-1:0]    m_tdata;   // [31:0] pixel_out
    logic                  m_tlast;

    // shadow of the block: tile store, fill count and registers
    logic [PIXEL_W-1:0]    tile_mem [STORE_DEPTH];
    int                    fill_count;
    logic [CFG_DATA_W-1:0] side_reg;
    logic [MODE_W-1:0]     mode_reg;

    out_pixel_t expected_pixels[$];

    int src_idle_pct;
    int snk_stall_pct;
    int err_count;
    int pixels_in;
    int pixels_out;
    int tiles_done;
    int mode_hits [4];
    int cycles;

    square_tile_rotate_flip #(
        .MAX_SIDE (MAX_SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int side_in_use();
        if (side_reg == 0)
            return 1;
        if (side_reg > MAX_SIDE)
            return MAX_SIDE;
        return int'(side_reg);
    endfunction

    // mostly small tiles; now and then side zero or a full / oversized one
    function automatic logic [CFG_DATA_W-1:0] pick_side();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return CFG_DATA_W'($urandom_range(1, 5));
        if (r == 7)
            return CFG_DATA_W'($urandom_range(6, 7));
        r = $urandom_range(8, 16);
        return (r == 16) ? '0 : CFG_DATA_W'(r);
    endfunction

    // store one pixel; returns 1 when it completes the tile and queues the output
    function automatic bit load_and_transform(input logic [PIXEL_W-1:0] px);
        int n;
        int src_row;
        int src_col;
        out_pixel_t op;
        n = side_in_use();
        if (fill_count < STORE_DEPTH)
            tile_mem[fill_count] = px;
        fill_count++;
        if (fill_count < n * n)
            return 1'b0;
        for (int y = 0; y < n; y++)
        begin
            for (int x = 0; x < n; x++)
            begin
                case (mode_reg)
                    MODE_ROT_CCW:
                    begin
                        src_row = x;
                        src_col = n - 1 - y;
                    end
                    MODE_ROT_CW:
                    begin
                        src_row = n - 1 - x;
                        src_col = y;
                    end
                    MODE_MIRROR_ROW:
                    begin
                        src_row = n - 1 - y;
                        src_col = x;
                    end
                    default:
                    begin
                        src_row = y;
                        src_col = n - 1 - x;
                    end
                endcase
                op.pixel = tile_mem[src_row * n + src_col];
                op.last  = (y == n - 1) && (x == n - 1);
                expected_pixels.push_back(op);
            end
        end
        fill_count = 0;
        tiles_done++;
        mode_hits[mode_reg]++;
        return 1'b1;
    endfunction

    // valid is left high after the transaction so back-to-back sends keep it asserted
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, output bit tile_complete);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
        tile_complete = load_and_transform(px);
        pixels_in++;
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_TILE_SIDE)
            side_reg = val;
        else
            mode_reg = val[MODE_W-1:0];
        @(posedge clk);
    endtask

    // shrink the side below the fill count: the next pixel must flush the tile
    task automatic test_resize_mid_tile();
        bit done;
        send_pixel(32'h0000_0000, done);
        send_pixel(32'hFFFF_FFFF, done);
        send_pixel(32'hAAAA_AAAA, done);
        send_pixel(32'h5555_5555, done);
        send_pixel(32'h0000_0001, done);
        drain_and_settle();
        write_reg(REG_TILE_SIDE, CFG_DATA_W'(2));
        send_pixel(32'h8000_0000, done);
        drain_and_settle();
    endtask

    task automatic side2_tile(input logic [MODE_W-1:0] mode);
        bit done;
        write_reg(REG_TILE_SIDE, CFG_DATA_W'(2));
        write_reg(REG_TRANSFORM_MODE, CFG_DATA_W'(mode));
        for (int i = 0; i < 4; i++)
            send_pixel({8'hC0 | 8'(mode), 20'h0, 4'(i)}, done);
        drain_and_settle();
    endtask

    task automatic test_each_transform();
        side2_tile(MODE_ROT_CCW);
        side2_tile(MODE_ROT_CW);
        side2_tile(MODE_MIRROR_ROW);
        side2_tile(MODE_MIRROR_COL);
    endtask

    // side zero behaves as side one
    task automatic test_smallest_sides();
        bit done;
        write_reg(REG_TILE_SIDE, CFG_DATA_W'(0));
        write_reg(REG_TRANSFORM_MODE, CFG_DATA_W'(MODE_MIRROR_COL));
        send_pixel(32'hFFFF_FFFF, done);
        drain_and_settle();
        write_reg(REG_TILE_SIDE, CFG_DATA_W'(1));
        write_reg(REG_TRANSFORM_MODE, CFG_DATA_W'(MODE_ROT_CCW));
        send_pixel(32'h0000_0000, done);
        drain_and_settle();
    endtask

    task automatic random_tile(input logic [CFG_DATA_W-1:0] side, input bit allow_resize);
        bit done;
        int n;
        int k;
        done = 1'b0;
        write_reg(REG_TILE_SIDE, side);
        write_reg(REG_TRANSFORM_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        n = side_in_use();
        if (allow_resize && n > 1 && $urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(1, n * n - 1);
            for (int i = 0; i < k; i++)
                send_pixel($urandom, done);
            drain_and_settle();
            write_reg(REG_TILE_SIDE, pick_side());
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_TRANSFORM_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        end
        while (!done)
            send_pixel($urandom, done);
        drain_and_settle();
    endtask

    task automatic test_random_tiles(input int src_pct, input int snk_pct,
                                     input logic [CFG_DATA_W-1:0] first_side,
                                     input int min_pixels);
        int start;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start = pixels_in;
        random_tile(first_side, 1'b0);
        while (pixels_in - start < min_pixels)
            random_tile(pick_side(), 1'b1);
    endtask

    // output side: random stalls, compare each transaction with the oldest expectation
    initial
    begin
        out_pixel_t want;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: unexpected output pixel %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_out++;
                    if (m_tdata !== want.pixel || m_tlast !== want.last)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("ERROR: pixel exp %h got %h, last exp %b got %b",
                                     want.pixel, m_tdata, want.last, m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d pixels pending",
                         cycles, expected_pixels.size());
                $display("tb_square_tile_rotate_flip: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        fill_count    = 0;
        side_reg      = TILE_SIDE_RESET;
        mode_reg      = MODE_ROT_CCW;
        err_count     = 0;
        pixels_in     = 0;
        pixels_out    = 0;
        tiles_done    = 0;
        mode_hits     = '{0, 0, 0, 0};
        src_idle_pct  = 36;
        snk_stall_pct = 83;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_resize_mid_tile();
        test_each_transform();
        test_smallest_sides();
        // oversized side saturates to a full store
        test_random_tiles(36, 83, CFG_DATA_W'(15), 40);
        test_random_tiles(83, 36, CFG_DATA_W'(3), 9);
        test_random_tiles(0, 0, CFG_DATA_W'(2), 20);

        drain_and_settle();
        $display("%0d pixels in, %0d pixels out, %0d tiles, %0d mismatches",
                 pixels_in, pixels_out, tiles_done, err_count);
        $display("tiles per transform: ccw %0d, cw %0d, row mirror %0d, col mirror %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (err_count == 0 && expected_pixels.size() == 0)
            $display("tb_square_tile_rotate_flip: clean");
        else
            $display("tb_square_tile_rotate_flip: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/strf_pkg.sv
rtl/core/strf_ctrl.sv
rtl/core/strf_dp.sv
rtl/core/square_tile_rotate_flip.sv
test/tb_square_tile_rotate_flip.sv
